@@ rtl/rss_pkg.sv @@
// Shared package for the repeat spacing run segmenter.
// Holds field widths, register indexes, reset values and the result record.
// No dependencies.
package rss_pkg;

    localparam int COORD_BITS_DEF     = 31;
    localparam int RUN_COUNT_BITS_DEF = 16;

    localparam int ID_BITS        = 20;
    localparam int SIZE_BITS      = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int OUT_DATA_BITS  = ((ID_BITS + SIZE_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS  = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_TOL         = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_FAMILY_SIZE = CFG_INDEX_BITS'(1);

    localparam logic [CFG_DATA_BITS-1:0] GAP_TOL_RST         = CFG_DATA_BITS'(20);
    localparam logic [CFG_DATA_BITS-1:0] MIN_FAMILY_SIZE_RST = CFG_DATA_BITS'(3);

    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

    typedef struct packed {
        logic [ID_BITS-1:0]   member_id;
        logic                 member_added;
        logic                 run_closed;
        logic                 run_kept;
        logic [SIZE_BITS-1:0] closed_run_size;
        logic                 family_done;
    } result_t;

endpackage

@@ rtl/repeat_spacing_run_segmenter.sv @@
// Top level of the repeat spacing run segmenter: state, gap check and output skid stage.
// Depends on rss_pkg for widths, register indexes and the result record.
//
// Members of one family arrive on the s_ channel in ascending start order, one
// transaction each, with s_tlast marking the final member. Every member gives
// exactly one result transaction on the m_ channel: the member id and the size
// of a run that closed at it in m_tdata, and the added, closed and kept flags
// in m_tuser. m_tlast echoes the family end.
// The cfg_ channel writes the largest allowed gap difference (index 0) and the
// smallest kept run size (index 1); other indexes are ignored. cfg_ready is
// always high, and writes belong only between families while no result is outstanding.
// One member is taken in every cycle while the skid register is empty; the
// path that sets this is the gap difference (two adds, a subtract and a
// compare) feeding the result register.
// Reset clears the family state, loads 20 and 3 into the two registers and
// empties the output stages, so s_tready is high once reset is released.
// When the receiver stalls, one more result is held in a skid register; after
// that s_tready drops until the output register drains.
module repeat_spacing_run_segmenter #(
    parameter int COORD_BITS     = rss_pkg::COORD_BITS_DEF,
    parameter int RUN_COUNT_BITS = rss_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // member_start, member_end, member_id, zero padding.
    input  logic [((2*COORD_BITS+rss_pkg::ID_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_member_id, closed_run_size, zero padding.
    output logic [rss_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // member_added, run_closed, run_kept.
    output logic [rss_pkg::OUT_USER_BITS-1:0]  m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rss_pkg::*;

    localparam int SUM_BITS = COORD_BITS + 1;
    localparam int CMP_BITS = (RUN_COUNT_BITS > SIZE_BITS) ? RUN_COUNT_BITS : SIZE_BITS;
    localparam logic [RUN_COUNT_BITS-1:0] RUN_ONE = RUN_COUNT_BITS'(1);
    localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = '1;
    localparam logic [1:0] POS_TWO = 2'd2;

    logic [CFG_DATA_BITS-1:0]  gap_tol_reg;
    logic [CFG_DATA_BITS-1:0]  min_family_size_reg;

    logic [COORD_BITS-1:0]     prev_start_reg, prev_start_next;
    logic [COORD_BITS-1:0]     prev_end_reg, prev_end_next;
    logic [COORD_BITS-1:0]     prev_prev_end_reg, prev_prev_end_next;
    logic [1:0]                position_reg, position_next;
    logic [RUN_COUNT_BITS-1:0] run_size_reg, run_size_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      skid_valid_reg, skid_valid_next;
    result_t                   out_reg;
    result_t                   skid_reg;
    result_t                   result;

    logic                      accept;
    logic                      out_free;
    logic [COORD_BITS-1:0]     member_start;
    logic [COORD_BITS-1:0]     member_end;
    logic [ID_BITS-1:0]        member_id;
    logic [SUM_BITS-1:0]       sum_new;
    logic [SUM_BITS-1:0]       sum_old;
    logic [SUM_BITS-1:0]       gap_diff;
    logic                      gap_ok;
    logic                      early;
    logic                      added;
    logic                      broke;
    logic [RUN_COUNT_BITS-1:0] run_grown;
    logic [RUN_COUNT_BITS-1:0] run_after;
    logic [RUN_COUNT_BITS-1:0] closing_size;
    logic [CMP_BITS-1:0]       closing_wide;
    logic                      closed;

    assign member_start = s_tdata[COORD_BITS-1:0];
    assign member_end   = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign member_id    = s_tdata[2*COORD_BITS+ID_BITS-1:2*COORD_BITS];

    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        sum_new   = {1'b0, member_start} + {1'b0, prev_prev_end_reg};
        sum_old   = {1'b0, prev_end_reg} + {1'b0, prev_start_reg};
        gap_diff  = (sum_new > sum_old) ? (sum_new - sum_old) : (sum_old - sum_new);
        gap_ok    = gap_diff <= {{(SUM_BITS-CFG_DATA_BITS){1'b0}}, gap_tol_reg};
        early     = position_reg < POS_TWO;
        added     = early || gap_ok;
        broke     = !added;
        run_grown = (run_size_reg == RUN_MAX) ? run_size_reg : run_size_reg + RUN_ONE;
        run_after = added ? run_grown : '0;

        closed       = broke || s_tlast;
        closing_size = broke ? run_size_reg : run_after;
        closing_wide = CMP_BITS'(closing_size);

        result.member_id    = member_id;
        result.member_added = added;
        result.run_closed   = closed;
        result.run_kept     = closed
                              && (closing_wide >= CMP_BITS'(min_family_size_reg));
        if (!closed)
        begin
            result.closed_run_size = '0;
        end
        else if (closing_wide > CMP_BITS'(SIZE_MAX))
        begin
            result.closed_run_size = SIZE_MAX;
        end
        else
        begin
            result.closed_run_size = closing_wide[SIZE_BITS-1:0];
        end
        result.family_done = s_tlast;

        prev_start_next    = prev_start_reg;
        prev_end_next      = prev_end_reg;
        prev_prev_end_next = prev_prev_end_reg;
        position_next      = position_reg;
        run_size_next      = run_size_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                prev_start_next    = '0;
                prev_end_next      = '0;
                prev_prev_end_next = '0;
                position_next      = '0;
                run_size_next      = '0;
            end
            else
            begin
                prev_start_next    = member_start;
                prev_end_next      = member_end;
                prev_prev_end_next = prev_end_reg;
                position_next      = early ? position_reg + 2'd1 : position_reg;
                run_size_next      = run_after;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || accept;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_tol_reg         <= GAP_TOL_RST;
            min_family_size_reg <= MIN_FAMILY_SIZE_RST;
            prev_start_reg      <= '0;
            prev_end_reg        <= '0;
            prev_prev_end_reg   <= '0;
            position_reg        <= '0;
            run_size_reg        <= '0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GAP_TOL)
                begin
                    gap_tol_reg <= cfg_data;
                end
                else if (cfg_index == REG_MIN_FAMILY_SIZE)
                begin
                    min_family_size_reg <= cfg_data;
                end
            end
            prev_start_reg    <= prev_start_next;
            prev_end_reg      <= prev_end_next;
            prev_prev_end_reg <= prev_prev_end_next;
            position_reg      <= position_next;
            run_size_reg      <= run_size_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS-ID_BITS-SIZE_BITS){1'b0}},
                       out_reg.closed_run_size, out_reg.member_id};
    assign m_tuser  = {out_reg.run_kept, out_reg.run_closed, out_reg.member_added};
    assign m_tlast  = out_reg.family_done;

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("family end delivered without a closed run");

    a_kept_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1])
        else $error("run kept without being closed");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_family_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> position_reg == '0 && run_size_reg == '0)
        else $error("family state not cleared after the last member");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for repeat_spacing_run_segmenter: directed and random member streams,
// a local gap-spacing predictor, and result checks against m_ transactions.
// Depends on rss_pkg and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rss_pkg::*;

    localparam int COORD        = COORD_BITS_DEF;
    localparam int IN_DATA_BITS = ((2 * COORD + ID_BITS + 7) / 8) * 8;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = CFG_INDEX_BITS'(2);

    typedef struct packed {
        logic [COORD-1:0]   mstart;
        logic [COORD-1:0]   mstop;
        logic [ID_BITS-1:0] mid;
        logic               mlast;
    } member_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata = '0;
    logic                      s_tlast = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic [OUT_USER_BITS-1:0]  m_tuser;
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    member_t member_backlog[$];
    result_t pending_results[$];
    logic    in_fire = 1'b0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      stall_req = 0;
    int      stall_seen = 0;
    int      stall_left = 0;
    int      members_queued = 0;
    int      mismatches = 0;
    int      quiet_cycles = 0;

    logic [COORD-1:0]         last_start;
    logic [COORD-1:0]         last_stop;
    logic [COORD-1:0]         older_stop;
    logic [1:0]               seen_cnt;
    logic [SIZE_BITS-1:0]     run_len;
    logic [CFG_DATA_BITS-1:0] space_tol;
    logic [CFG_DATA_BITS-1:0] keep_min;

    repeat_spacing_run_segmenter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t segment_member(input member_t m);
        logic [COORD:0] lhs;
        logic [COORD:0] rhs;
        logic [COORD:0] delta;
        result_t        r;
        r = '0;
        r.member_id = m.mid;
        r.family_done = m.mlast;
        if (seen_cnt < 2'd2)
        begin
            r.member_added = 1'b1;
            if (run_len != SIZE_MAX)
                run_len = run_len + 1'b1;
            seen_cnt = seen_cnt + 1'b1;
        end
        else
        begin
            lhs = {1'b0, m.mstart} + {1'b0, older_stop};
            rhs = {1'b0, last_stop} + {1'b0, last_start};
            delta = (lhs > rhs) ? lhs - rhs : rhs - lhs;
            if (delta <= space_tol)
            begin
                r.member_added = 1'b1;
                if (run_len != SIZE_MAX)
                    run_len = run_len + 1'b1;
            end
            else
            begin
                r.run_closed = 1'b1;
                r.run_kept = (run_len >= keep_min);
                r.closed_run_size = run_len;
                run_len = '0;
            end
        end
        older_stop = last_stop;
        last_start = m.mstart;
        last_stop = m.mstop;
        if (m.mlast)
        begin
            if (!r.run_closed)
            begin
                r.run_closed = 1'b1;
                r.run_kept = (run_len >= keep_min);
                r.closed_run_size = run_len;
            end
            last_start = '0;
            last_stop = '0;
            older_stop = '0;
            seen_cnt = '0;
            run_len = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sender: an offered transaction is held until it is accepted.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !in_fire)
            s_tvalid <= 1'b1;
        else if (member_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tdata <= IN_DATA_BITS'({member_backlog[0].mid, member_backlog[0].mstop,
                                      member_backlog[0].mstart});
            s_tlast <= member_backlog[0].mlast;
        end
        else
            s_tvalid <= 1'b0;
    end

    // Receiver, with a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_seen != stall_req)
        begin
            stall_seen = stall_req;
            stall_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
            space_tol = GAP_TOL_RST;
            keep_min = MIN_FAMILY_SIZE_RST;
            last_start = '0;
            last_stop = '0;
            older_stop = '0;
            seen_cnt = '0;
            run_len = '0;
        end
        else
        begin
            in_fire <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GAP_TOL)
                    space_tol = cfg_data;
                else if (cfg_index == REG_MIN_FAMILY_SIZE)
                    keep_min = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                if (member_backlog.size() == 0)
                begin
                    $display("%0t ns: input transaction with no member offered", $time);
                    mismatches++;
                end
                else
                    pending_results.insert(pending_results.size(),
                                           segment_member(member_backlog.pop_front()));
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result transaction, id %0h",
                             $time, m_tdata[ID_BITS-1:0]);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    got.member_id = m_tdata[ID_BITS-1:0];
                    got.closed_run_size = m_tdata[ID_BITS+SIZE_BITS-1:ID_BITS];
                    got.member_added = m_tuser[0];
                    got.run_closed = m_tuser[1];
                    got.run_kept = m_tuser[2];
                    got.family_done = m_tlast;
                    check_field("member_id", want.member_id, got.member_id);
                    check_field("member_added", want.member_added, got.member_added);
                    check_field("run_closed", want.run_closed, got.run_closed);
                    check_field("run_kept", want.run_kept, got.run_kept);
                    check_field("closed_run_size", want.closed_run_size, got.closed_run_size);
                    check_field("family_done", want.family_done, got.family_done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[repeat_spacing_run_segmenter] ERROR");
                $finish;
            end
        end
    end

    task automatic push_member(input longint st, input longint sp, input int id, input bit lst);
        member_t m;
        m.mstart = st[COORD-1:0];
        m.mstop = sp[COORD-1:0];
        m.mid = id[ID_BITS-1:0];
        m.mlast = lst;
        member_backlog.insert(member_backlog.size(), m);
        members_queued++;
    endtask

    // One family: steady spacing with jitter inside the tolerance, occasional
    // breaks, and some families of unordered noise.
    task automatic gen_family();
        int     count;
        int     jit;
        bit     noise;
        longint cur_end;
        longint g0;
        longint gap;
        longint st;
        count = ($urandom_range(99) < 10) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        jit = (space_tol > 1000) ? 1000 : int'(space_tol);
        noise = ($urandom_range(99) < 15);
        cur_end = longint'($urandom);
        g0 = longint'($urandom_range(0, 3300)) - 300;
        for (int i = 0; i < count; i++)
        begin
            gap = g0 + longint'($urandom_range(0, jit));
            if (i >= 2 && $urandom_range(99) < 8)
                gap = gap + longint'(space_tol) + jit + 1 + longint'($urandom_range(0, 50000));
            st = cur_end + gap;
            cur_end = st + longint'($urandom_range(400, 2000));
            if (noise)
            begin
                st = longint'($urandom);
                cur_end = longint'($urandom);
            end
            push_member(st, cur_end, $urandom_range(0, 20'hFFFFF), i == count - 1);
        end
    endtask

    task automatic fill(input int n);
        int goal;
        goal = members_queued + n;
        while (members_queued < goal)
            gen_family();
    endtask

    task automatic wait_idle();
        while (member_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_UNUSED, $urandom);
        push_member(1000, 1100, 0, 1'b1);
        push_member(0, 0, 20'hFFFFF, 1'b0);
        push_member(100, 150, 1, 1'b0);
        push_member(250, 300, 2, 1'b0);
        push_member(400, 450, 3, 1'b1);
        push_member(0, 10, 4, 1'b0);
        push_member(100, 110, 5, 1'b0);
        push_member(200, 210, 6, 1'b0);
        push_member(900, 910, 7, 1'b0);
        push_member(1000, 1010, 8, 1'b0);
        push_member(1100, 1110, 9, 1'b1);
        push_member(0, 10, 10, 1'b0);
        push_member(100, 110, 11, 1'b0);
        push_member(200, 210, 12, 1'b0);
        push_member(5000, 5010, 13, 1'b1);
        push_member(31'h7FFF_FFFF, 31'h7FFF_FFFF, 14, 1'b0);
        push_member(0, 31'h7FFF_FFFF, 15, 1'b0);
        push_member(31'h7FFF_FFFF, 0, 16, 1'b0);
        push_member(0, 0, 17, 1'b1);
        push_member(0, 10, 18, 1'b0);
        push_member(100, 110, 19, 1'b0);
        push_member(220, 230, 20, 1'b0);
        push_member(361, 371, 21, 1'b1);
        wait_idle();

        write_reg(REG_GAP_TOL, 0);
        write_reg(REG_MIN_FAMILY_SIZE, 0);
        push_member(0, 10, 22, 1'b0);
        push_member(20, 30, 23, 1'b0);
        push_member(40, 50, 24, 1'b1);
        push_member(0, 10, 25, 1'b0);
        push_member(20, 30, 26, 1'b0);
        push_member(41, 51, 27, 1'b1);
        wait_idle();

        send_idle_pct = 38;
        recv_idle_pct = 82;
        write_reg(REG_GAP_TOL, $urandom_range(1, 300));
        write_reg(REG_MIN_FAMILY_SIZE, $urandom_range(1, 6));
        fill(350);
        wait_idle();

        send_idle_pct = 82;
        recv_idle_pct = 38;
        write_reg(REG_GAP_TOL, 65535);
        write_reg(REG_MIN_FAMILY_SIZE, 1);
        fill(350);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_GAP_TOL, $urandom_range(0, 2000));
        write_reg(REG_MIN_FAMILY_SIZE, $urandom_range(2, 10));
        fill(300);
        stall_req++;
        wait_idle();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[repeat_spacing_run_segmenter] OK");
        else
            $display("[repeat_spacing_run_segmenter] ERROR");
        $finish;
    end

endmodule
